// ===== hdl/lrsa_pkg.sv =====
// Shared types, constants and helpers for the LRU register slot allocator.
`timescale 1ns / 1ps

package lrsa_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int STAMP_W        = 32;
    localparam int FLAG_WRITE_BIT = 1;
    localparam int FLAG_ADDR_BIT  = 3;

    localparam logic [3:0] FLAGS_WRITE_ONLY = 4'b0010;
    localparam logic [3:0] SIZE_ADDR_OF     = 4'd8;

    typedef enum logic [2:0] {
        OP_ACCESS   = 3'd0,
        OP_RELEASE  = 3'd1,
        OP_LOCK     = 3'd2,
        OP_UNLOCK   = 3'd3,
        OP_REASSIGN = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic        key_valid;
        logic [3:0]  var_size;
        logic [3:0]  access_flags;
        logic [3:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  slot;
        logic        hit;
        logic        writeback;
        logic [31:0] writeback_key;
        logic [3:0]  writeback_size;
        logic        error;
    } t_out_item;

    // status gathered by the slot scan
    typedef struct packed {
        logic hit;
        logic found_free;
        logic have_lru;
    } t_scan_flags;

    function automatic logic size_ok(input logic [3:0] s);
        return (s == 4'd1) || (s == 4'd2) || (s == 4'd4) || (s == 4'd8);
    endfunction

endpackage

// ===== hdl/lrsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lrsa_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lrsa_scan.sv =====
// Slot scan: first key hit, first free slot and least recently used victim.
`timescale 1ns / 1ps

module lrsa_scan #(
    parameter  int NUM_SLOTS = lrsa_pkg::NUM_SLOTS_DEF,
    parameter  int KEY_BITS  = lrsa_pkg::KEY_BITS_DEF,
    localparam int SW        = $clog2(NUM_SLOTS),
    localparam int ENT_W     = KEY_BITS + 9 + lrsa_pkg::STAMP_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_eval,
    input  logic [SW-1:0]         i_eval_idx,
    input  logic [ENT_W-1:0]      i_ent,
    input  logic                  i_in_use,
    input  logic                  i_locked,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic                  i_key_valid,
    output lrsa_pkg::t_scan_flags o_flags,
    output logic [SW-1:0]         o_hit_idx,
    output logic [SW-1:0]         o_free_idx,
    output logic [SW-1:0]         o_lru_idx,
    output logic [ENT_W-1:0]      o_hit_ent,
    output logic [ENT_W-1:0]      o_lru_ent
);

    import lrsa_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                kv;
        logic [3:0]          size;
        logic [3:0]          flags;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    t_entry      ent;
    t_entry      r_hit_ent;
    t_entry      r_lru_ent;
    t_scan_flags r_flags;
    logic [SW-1:0] r_hit_idx;
    logic [SW-1:0] r_free_idx;
    logic [SW-1:0] r_lru_idx;
    logic usable;
    logic hit_now;
    logic free_now;
    logic lru_better;

    assign ent      = t_entry'(i_ent);
    assign usable   = i_in_use && !i_locked;
    assign hit_now  = usable && ent.kv && i_key_valid && (ent.key == i_key);
    assign free_now = !i_in_use && !i_locked;
    // strict compare keeps the lowest index on equal stamps
    assign lru_better = usable && (!r_flags.have_lru || (ent.stamp < r_lru_ent.stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_eval) begin
            if (hit_now) begin
                r_flags.hit <= 1'b1;
            end
            if (free_now) begin
                r_flags.found_free <= 1'b1;
            end
            if (lru_better) begin
                r_flags.have_lru <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_eval && !i_start) begin
            if (hit_now && !r_flags.hit) begin
                r_hit_idx <= i_eval_idx;
                r_hit_ent <= ent;
            end
            if (free_now && !r_flags.found_free) begin
                r_free_idx <= i_eval_idx;
            end
            if (lru_better) begin
                r_lru_idx <= i_eval_idx;
                r_lru_ent <= ent;
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;
    assign o_lru_idx  = r_lru_idx;
    assign o_hit_ent  = r_hit_ent;
    assign o_lru_ent  = r_lru_ent;

endmodule

// ===== hdl/lru_register_slot_allocator.sv =====
// Top level: LRU register slot allocator with slot table RAM and sequencer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | to block  | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | from block| o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// An access item is accepted, then every slot is read in turn from the table RAM through its single
// read port, the last read is evaluated in the scan, and the item commits.
// Release and reassign with a valid slot index read their slot (one RAM read) first; other ops commit directly.
// One item is in flight; the next is accepted while the last result waits.
// A stalled output holds the commit of the following item in its final cycle.
// Reset clears the in-use and lock bits and the access clock; no clearing pass.
`timescale 1ns / 1ps

module lru_register_slot_allocator #(
    parameter int NUM_SLOTS = lrsa_pkg::NUM_SLOTS_DEF,
    parameter int KEY_BITS  = lrsa_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrsa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lrsa_pkg::t_out_item o_out_item
);

    import lrsa_pkg::*;

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W = KEY_BITS + 9 + STAMP_W;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                kv;
        logic [3:0]          size;
        logic [3:0]          flags;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SLOT,
        S_DONE
    } t_state;

    t_state             r_state;
    t_in_item           r_item;
    logic [CW-1:0]      r_cnt;
    logic [NUM_SLOTS-1:0] r_in_use;
    logic [NUM_SLOTS-1:0] r_locked;
    logic [STAMP_W-1:0] r_clock;
    t_out_item          r_out;
    logic               r_out_vld;

    t_out_item          n_out;
    logic [NUM_SLOTS-1:0] n_in_use;
    logic [NUM_SLOTS-1:0] n_locked;
    logic [STAMP_W-1:0] n_clock;

    logic               accept;
    logic               commit;
    logic               in_idx_ok;
    logic               item_idx_ok;
    logic [KEY_BITS-1:0] key_m;
    logic [SW-1:0]      item_slot;

    logic               ram_we;
    logic               wr_req;
    logic [SW-1:0]      wr_addr;
    t_entry             wr_ent;
    logic               ram_re;
    logic [SW-1:0]      ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    t_entry             rd_ent;

    logic               scan_eval;
    logic [SW-1:0]      scan_idx;
    t_scan_flags        scan_flags;
    logic [SW-1:0]      hit_idx;
    logic [SW-1:0]      free_idx;
    logic [SW-1:0]      lru_idx;
    logic [ENT_W-1:0]   hit_ent_w;
    logic [ENT_W-1:0]   lru_ent_w;
    t_entry             hit_ent;
    t_entry             lru_ent;
    logic [SW-1:0]      pick;

    assign accept      = i_in_valid && o_in_ready;
    assign commit      = (r_state == S_DONE) && (!r_out_vld || i_out_ready);
    assign in_idx_ok   = {28'd0, i_in_item.slot_index} < 32'(NUM_SLOTS);
    assign item_idx_ok = {28'd0, r_item.slot_index} < 32'(NUM_SLOTS);
    assign key_m       = KEY_BITS'(r_item.key);
    assign item_slot   = SW'(r_item.slot_index);
    assign rd_ent      = t_entry'(ram_rdata);
    assign hit_ent     = t_entry'(hit_ent_w);
    assign lru_ent     = t_entry'(lru_ent_w);

    // table read port: one slot per cycle while scanning, the target slot otherwise
    assign ram_re    = ((r_state == S_SCAN) && (r_cnt < CW'(NUM_SLOTS))) || (r_state == S_SLOT);
    assign ram_raddr = (r_state == S_SLOT) ? item_slot : r_cnt[SW-1:0];
    assign scan_eval = (r_state == S_SCAN) && (r_cnt != '0);
    assign scan_idx  = SW'(r_cnt - CW'(1));
    assign ram_we    = commit && wr_req;

    lrsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_ent),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lrsa_scan #(
        .NUM_SLOTS (NUM_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_eval      (scan_eval),
        .i_eval_idx  (scan_idx),
        .i_ent       (ram_rdata),
        .i_in_use    (r_in_use[scan_idx]),
        .i_locked    (r_locked[scan_idx]),
        .i_key       (key_m),
        .i_key_valid (r_item.key_valid),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_free_idx  (free_idx),
        .o_lru_idx   (lru_idx),
        .o_hit_ent   (hit_ent_w),
        .o_lru_ent   (lru_ent_w)
    );

    // no free slot and no unlocked candidate falls back to slot 0
    assign pick = scan_flags.found_free ? free_idx :
                  (scan_flags.have_lru ? lru_idx : '0);

    always_comb begin
        n_out    = '0;
        n_in_use = r_in_use;
        n_locked = r_locked;
        n_clock  = r_clock;
        wr_req   = 1'b0;
        wr_addr  = '0;
        wr_ent   = '0;
        unique case (t_op'(r_item.op))
            OP_ACCESS: begin
                if (scan_flags.hit) begin
                    n_clock      = r_clock + STAMP_W'(1);
                    wr_req       = 1'b1;
                    wr_addr      = hit_idx;
                    wr_ent       = hit_ent;
                    wr_ent.flags = hit_ent.flags | r_item.access_flags;
                    wr_ent.stamp = n_clock;
                    n_out.slot   = 4'(hit_idx);
                    n_out.hit    = 1'b1;
                end else if (!size_ok(r_item.var_size) ||
                             (r_item.access_flags[FLAG_ADDR_BIT] &&
                              (r_item.var_size != SIZE_ADDR_OF))) begin
                    n_out.error = 1'b1;
                end else begin
                    n_clock = r_clock + STAMP_W'(1);
                    if (!scan_flags.found_free && scan_flags.have_lru &&
                        lru_ent.kv && lru_ent.flags[FLAG_WRITE_BIT]) begin
                        n_out.writeback      = 1'b1;
                        n_out.writeback_key  = 32'(lru_ent.key);
                        n_out.writeback_size = lru_ent.size;
                    end
                    wr_req         = 1'b1;
                    wr_addr        = pick;
                    wr_ent.key     = r_item.key_valid ? key_m : '0;
                    wr_ent.kv      = r_item.key_valid;
                    wr_ent.size    = r_item.var_size;
                    wr_ent.flags   = r_item.access_flags;
                    wr_ent.stamp   = n_clock;
                    n_in_use[pick] = 1'b1;
                    n_locked[pick] = 1'b0;
                    n_out.slot     = 4'(pick);
                end
            end
            OP_RELEASE: begin
                n_out.slot = r_item.slot_index;
                if (item_idx_ok) begin
                    if (r_in_use[item_slot] && !r_locked[item_slot] &&
                        rd_ent.kv && rd_ent.flags[FLAG_WRITE_BIT]) begin
                        n_out.writeback      = 1'b1;
                        n_out.writeback_key  = 32'(rd_ent.key);
                        n_out.writeback_size = rd_ent.size;
                    end
                    n_in_use[item_slot] = 1'b0;
                    n_locked[item_slot] = 1'b0;
                end
            end
            OP_LOCK: begin
                n_out.slot = r_item.slot_index;
                if (item_idx_ok) begin
                    n_locked[item_slot] = 1'b1;
                end
            end
            OP_UNLOCK: begin
                n_out.slot = r_item.slot_index;
                if (item_idx_ok) begin
                    n_locked[item_slot] = 1'b0;
                end
            end
            OP_REASSIGN: begin
                n_out.slot = r_item.slot_index;
                if (item_idx_ok) begin
                    if (!size_ok(r_item.var_size)) begin
                        n_out.slot  = '0;
                        n_out.error = 1'b1;
                    end else begin
                        if (r_in_use[item_slot] && !r_locked[item_slot] &&
                            rd_ent.kv && rd_ent.flags[FLAG_WRITE_BIT]) begin
                            n_out.writeback      = 1'b1;
                            n_out.writeback_key  = 32'(rd_ent.key);
                            n_out.writeback_size = rd_ent.size;
                        end
                        wr_req              = 1'b1;
                        wr_addr             = item_slot;
                        wr_ent.key          = r_item.key_valid ? key_m : '0;
                        wr_ent.kv           = r_item.key_valid;
                        wr_ent.size         = r_item.var_size;
                        wr_ent.flags        = FLAGS_WRITE_ONLY;
                        wr_ent.stamp        = r_clock;
                        n_in_use[item_slot] = 1'b1;
                        n_locked[item_slot] = 1'b0;
                    end
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_in_use  <= '0;
            r_locked  <= '0;
            r_clock   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready && !commit) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= i_in_item;
                        r_cnt  <= '0;
                        if (i_in_item.op == OP_ACCESS) begin
                            r_state <= S_SCAN;
                        end else if (in_idx_ok && ((i_in_item.op == OP_RELEASE) ||
                                                   (i_in_item.op == OP_REASSIGN))) begin
                            r_state <= S_SLOT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NUM_SLOTS)) begin
                        r_state <= S_DONE;
                    end
                end
                S_SLOT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (commit) begin
                        r_out     <= n_out;
                        r_out_vld <= 1'b1;
                        r_in_use  <= n_in_use;
                        r_locked  <= n_locked;
                        r_clock   <= n_clock;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_write_only_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DONE) &&
                   ((r_item.op == OP_ACCESS) || (r_item.op == OP_REASSIGN)))
        else $error("table written outside an access or reassign commit");

    a_clock_moves_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_clock != $past(r_clock))) |->
            $past(commit && (r_item.op == OP_ACCESS)))
        else $error("access clock advanced without an access commit");

    a_hit_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.hit) |-> (!r_out.error && !r_out.writeback))
        else $error("hit result carries error or writeback");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CW'(NUM_SLOTS)))
        else $error("scan counter ran past the slot count");
`endif

endmodule
